@@ rtl/binomial_coefficient_pascal_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef BINOMIAL_COEFFICIENT_PASCAL_MACROS_SVH
`define BINOMIAL_COEFFICIENT_PASCAL_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on i_clk, off while in reset.
`define BCP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bcp assertion failed");

// Next-cycle implication, clocked on i_clk, off while in reset.
`define BCP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bcp assertion failed");

`else

`define BCP_ASSERT_IMP(label, ante, cons)
`define BCP_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ rtl/bcp_pkg.sv @@
package bcp_pkg;

    localparam int COEF_W    = 60;
    localparam int IDX_W     = 6;
    localparam int ROW_DEPTH = 64;
    localparam int MAX_N     = 63;

    typedef logic [COEF_W-1:0] t_coef;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_coef wdata;
        logic  re;
        t_idx  raddr;
    } t_ram_ctrl;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SEED    = 3'd1;
    localparam logic [2:0] ST_ROW_RD  = 3'd2;
    localparam logic [2:0] ST_ROW_CAP = 3'd3;
    localparam logic [2:0] ST_STEP    = 3'd4;
    localparam logic [2:0] ST_FIN_RD  = 3'd5;
    localparam logic [2:0] ST_FIN_CAP = 3'd6;
    localparam logic [2:0] ST_ZERO    = 3'd7;

endpackage

@@ rtl/bcp_row_ram.sv @@
module bcp_row_ram
    import bcp_pkg::*;
(
    input  logic      i_clk,
    input  t_ram_ctrl i_ctrl,
    output t_coef     o_rd_data
);

    t_coef r_mem [ROW_DEPTH];
    t_coef r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_ctrl.waddr] <= i_ctrl.wdata;
        end
        if (i_ctrl.re) begin
            r_rd_data <= r_mem[i_ctrl.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/binomial_coefficient_pascal.sv @@
// A query writes row 0 up to entry k, then updates rows i=1..n in place (none when n or k
// is zero), entries min(i,k) down to 1, and last reads entry k for the result. Out-of-range
// queries (k>n) skip the rows and return zero.
// The single row RAM port pair and the one 60-bit adder serve every row; a query is taken
// only in the idle state, so one query is finished before the next is taken. A new query is
// taken while the previous result waits at the output.
// Reset (i_rst_n low, synchronous) clears the sequencer and output valid; the row RAM
// is not cleared, each query seeds the entries it reads.
`include "binomial_coefficient_pascal_macros.svh"

module binomial_coefficient_pascal
    import bcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [5:0] n, [11:6] k, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [59:0] coefficient, [63:60] zero
);

    logic [2:0] r_state, n_state;
    t_idx       r_n, n_n;
    t_idx       r_k, n_k;
    t_idx       r_i, n_i;
    t_idx       r_j, n_j;
    t_coef      r_cur, n_cur;
    logic       r_out_valid, n_out_valid;
    t_coef      r_out_data, n_out_data;

    t_ram_ctrl  ram_ctrl;
    t_coef      rd_data;
    t_idx       in_n;
    t_idx       in_k;
    t_idx       top;
    logic       s_accept;
    logic       out_free;

    assign in_n     = s_axis_tdata[5:0];
    assign in_k     = s_axis_tdata[11:6];
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign top      = (r_i < r_k) ? r_i : r_k;

    bcp_row_ram u_row_ram (
        .i_clk     (i_clk),
        .i_ctrl    (ram_ctrl),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_k         = r_k;
        n_i         = r_i;
        n_j         = r_j;
        n_cur       = r_cur;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ram_ctrl    = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_n = in_n;
                    n_k = in_k;
                    n_j = '0;
                    if (in_k > in_n || 7'(in_n) > 7'(MAX_N)) begin
                        n_state = ST_ZERO;
                    end else begin
                        n_state = ST_SEED;
                    end
                end
            end
            ST_SEED: begin
                // row 0: one at entry 0, zeros up to entry k
                ram_ctrl.we    = 1'b1;
                ram_ctrl.waddr = r_j;
                ram_ctrl.wdata = (r_j == '0) ? t_coef'(1) : '0;
                if (r_j == r_k) begin
                    n_i = t_idx'(1);
                    if (r_n == '0 || r_k == '0) begin
                        n_state = ST_FIN_RD;
                    end else begin
                        n_state = ST_ROW_RD;
                    end
                end else begin
                    n_j = r_j + t_idx'(1);
                end
            end
            ST_ROW_RD: begin
                ram_ctrl.re    = 1'b1;
                ram_ctrl.raddr = top;
                n_j            = top;
                n_state        = ST_ROW_CAP;
            end
            ST_ROW_CAP: begin
                n_cur          = rd_data;
                ram_ctrl.re    = 1'b1;
                ram_ctrl.raddr = r_j - t_idx'(1);
                n_state        = ST_STEP;
            end
            ST_STEP: begin
                // rd_data holds the old left neighbour; carry it down as the next entry
                ram_ctrl.we    = 1'b1;
                ram_ctrl.waddr = r_j;
                ram_ctrl.wdata = r_cur + rd_data;
                n_cur          = rd_data;
                if (r_j == t_idx'(1)) begin
                    if (r_i == r_n) begin
                        n_state = ST_FIN_RD;
                    end else begin
                        n_i     = r_i + t_idx'(1);
                        n_state = ST_ROW_RD;
                    end
                end else begin
                    n_j            = r_j - t_idx'(1);
                    ram_ctrl.re    = 1'b1;
                    ram_ctrl.raddr = r_j - t_idx'(2);
                end
            end
            ST_FIN_RD: begin
                ram_ctrl.re    = 1'b1;
                ram_ctrl.raddr = r_k;
                n_state        = ST_FIN_CAP;
            end
            ST_FIN_CAP: begin
                // hold until the output register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = rd_data;
                    n_state     = ST_IDLE;
                end
            end
            ST_ZERO: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_n        <= n_n;
        r_k        <= n_k;
        r_i        <= n_i;
        r_j        <= n_j;
        r_cur      <= n_cur;
        r_out_data <= n_out_data;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_data};

    `BCP_ASSERT_NXT(a_accept_leaves_idle, s_accept, r_state != ST_IDLE)
    `BCP_ASSERT_IMP(a_step_index_nonzero, r_state == ST_STEP, r_j != '0)
    `BCP_ASSERT_IMP(a_step_no_addr_clash, ram_ctrl.we && ram_ctrl.re,
                    ram_ctrl.waddr != ram_ctrl.raddr)
    `BCP_ASSERT_NXT(a_k_above_n_zero, s_accept && in_k > in_n, r_state == ST_ZERO)

endmodule

@@ tb/tb.sv @@
module tb;
    import bcp_pkg::*;

    localparam int    RAND_QUERIES = 290;
    localparam int    HOLD_CYCLES  = 6000;
    localparam int    DRAIN_CYCLES = 2500;
    localparam longint LIMIT_CYCLES = 3000000;
    localparam t_coef MID_COEF     = 60'd916312070471295267;

    typedef struct {
        t_idx  n;
        t_idx  k;
        t_coef coef;
    } choose_t;

    typedef struct {
        t_idx  n;
        t_idx  k;
        bit    known;
        t_coef coef;
    } query_row_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = '0;   // [5:0] n, [11:6] k, [15:12] zero
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [63:0] m_axis_tdata;         // [59:0] coefficient, [63:60] zero

    choose_t pending_coefs[$];
    choose_t offered_query;
    choose_t head_coef;
    int      errors       = 0;
    int      results_seen = 0;
    int      queries_sent = 0;
    longint  cycle_count  = 0;
    bit      hold_req     = 1'b0;
    bit      no_idle      = 1'b0;

    query_row_t directed_rows[18] = '{
        '{6'd0,  6'd0,  1'b1, 60'd1},
        '{6'd63, 6'd0,  1'b1, 60'd1},
        '{6'd63, 6'd63, 1'b1, 60'd1},
        '{6'd0,  6'd63, 1'b1, 60'd0},
        '{6'd63, 6'd31, 1'b1, MID_COEF},
        '{6'd63, 6'd32, 1'b1, MID_COEF},
        '{6'd63, 6'd1,  1'b1, 60'd63},
        '{6'd63, 6'd62, 1'b1, 60'd63},
        '{6'd1,  6'd1,  1'b1, 60'd1},
        '{6'd5,  6'd6,  1'b1, 60'd0},
        '{6'd62, 6'd63, 1'b1, 60'd0},
        '{6'd10, 6'd5,  1'b1, 60'd252},
        '{6'd40, 6'd20, 1'b0, 60'd0},
        '{6'd17, 6'd9,  1'b0, 60'd0},
        '{6'd1,  6'd0,  1'b1, 60'd1},
        '{6'd33, 6'd17, 1'b0, 60'd0},
        '{6'd42, 6'd21, 1'b0, 60'd0},
        '{6'd2,  6'd1,  1'b1, 60'd2}
    };

    binomial_coefficient_pascal u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Build rows 1..n of the triangle in place; 60-bit sums wrap like the block.
    function automatic t_coef pascal_choose(t_idx n, t_idx k);
        t_coef row [ROW_DEPTH];
        int    top;
        if (k > n || int'(n) > MAX_N) return '0;
        row[0] = 60'd1;
        for (int j = 1; j <= int'(k); j++) row[j] = '0;
        for (int i = 1; i <= int'(n); i++) begin
            top = (i < int'(k)) ? i : int'(k);
            for (int j = top; j > 0; j--) row[j] = row[j] + row[j-1];
        end
        return row[k];
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Check result beats first, then log the query beat of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (pending_coefs.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, got %0h", $time, m_axis_tdata);
                end else begin
                    head_coef = pending_coefs.pop_front();
                    if (m_axis_tdata !== {4'b0, head_coef.coef}) begin
                        errors++;
                        $display("%0t: coefficient mismatch n=%0d k=%0d expected %0d got %0d",
                                 $time, head_coef.n, head_coef.k, {4'b0, head_coef.coef},
                                 m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) pending_coefs.push_back(offered_query);
        end
    end

    task automatic send_query(t_idx n, t_idx k, bit known, t_coef coef);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        offered_query = '{n, k, known ? coef : pascal_choose(n, k)};
        s_axis_tdata  <= {4'b0, k, n};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        queries_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_coefs.size() != 0);
    endtask

    initial begin : result_sink
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) gap = HOLD_CYCLES;
            else if (no_idle) gap = 0;
            else gap = $urandom_range(0, 8);
            hold_req = 1'b0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin : query_source
        t_idx n;
        t_idx k;
        int   sel;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_query(directed_rows[r].n, directed_rows[r].k,
                       directed_rows[r].known, directed_rows[r].coef);

        for (int q = 0; q < RAND_QUERIES; q++) begin
            // stall the output long enough that the block backs up its input
            if (q == 40) hold_req = 1'b1;
            if (q == 120) wait_drained();
            no_idle = (q >= 200 && q < 240);
            sel = $urandom_range(0, 9);
            n   = t_idx'($urandom_range(0, 63));
            if (sel < 7) k = t_idx'($urandom_range(0, int'(n)));
            else if (sel < 9) k = t_idx'($urandom_range(0, 63));
            else k = (n == 6'd63) ? 6'd63 : t_idx'($urandom_range(int'(n) + 1, 63));
            send_query(n, k, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_coefs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_coefs.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_coefs.size());
        end

        $display("tb: %0d queries (%0d table rows), %0d results, %0d errors",
                 queries_sent, $size(directed_rows), results_seen, errors);
        $display("tb: edge rows, k above n, random stalls and one long output hold-off");
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
